[hw/rtl/hotp_pkg.sv]
// ----------------------------------------------------------------------------
// hotp_pkg
// Shared types and constants for the one-time code checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hotp_pkg;

    // input transfer payload
    typedef struct packed {
        logic        mode;
        logic [62:0] time_seconds;
        logic [19:0] candidate_code;
    } in_item_t;

    // result transfer payload
    typedef struct packed {
        logic        code_valid;
        logic [19:0] expected_code;
    } out_item_t;

    // configuration register indexes
    localparam logic [1:0] REG_KEY_FIRST = 2'd0;
    localparam logic [1:0] REG_KEY_LAST  = 2'd1;
    localparam logic [1:0] REG_EVENT_CNT = 2'd2;
    localparam logic [1:0] REG_TIME_STEP = 2'd3;

    localparam logic [7:0] PAD_INNER = 8'h36;
    localparam logic [7:0] PAD_OUTER = 8'h5c;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    // round constant by round number
    function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
        logic [31:0] k;
        begin
            if (rnd < 7'd20)
                k = 32'h5A827999;
            else if (rnd < 7'd40)
                k = 32'h6ED9EBA1;
            else if (rnd < 7'd60)
                k = 32'h8F1BBCDC;
            else
                k = 32'hCA62C1D6;
            return k;
        end
    endfunction

    // round function by round number
    function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (rnd < 7'd20)
                f = (b & c) | (~b & d);
            else if (rnd >= 7'd40 && rnd < 7'd60)
                f = (b & c) | (b & d) | (c & d);
            else
                f = b ^ c ^ d;
            return f;
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hotp_totp_code_check_top.sv]
// ----------------------------------------------------------------------------
// hotp_totp_code_check_top
// HOTP/TOTP six-digit code checker around one iterative SHA-1 core.
// ----------------------------------------------------------------------------
// Sequence: time mode first runs the time-window divide; both modes then run four
// SHA-1 compressions (start, 16-word load, 80 rounds, final add, done), the
// modulo (quotient estimate, back-multiply, correction) and the output register.
// One item at a time: in_stall is high outside the idle phase, and the next
// input is taken in the cycle after the result transfer.
// Reset: control and configuration registers (event counter 1, step 30); datapath registers are not reset.
`default_nettype none

module hotp_totp_code_check_top #(
    parameter int CODE_DIGITS = 6
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire hotp_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output hotp_pkg::out_item_t     out_data,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [63:0]        cfg_data
);

    import hotp_pkg::*;

    localparam int          MODW    = 27;
    localparam logic [MODW-1:0] MODULUS = MODW'(10 ** CODE_DIGITS);
    // floor(2^32 / modulus): quotient estimate is exact or one short
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(10 ** CODE_DIGITS));

    typedef enum logic [2:0] {
        P_IDLE, P_DIV, P_SHA_GO, P_SHA_WAIT, P_MOD, P_OUT
    } phase_t;

    // configuration registers
    logic [63:0] key_first_reg, event_cnt_reg;
    logic [15:0] key_last_reg;
    logic [7:0]  step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_first_reg <= '0;
            key_last_reg  <= '0;
            event_cnt_reg <= 64'd1;
            step_reg      <= 8'd30;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_FIRST: key_first_reg <= cfg_data;
                REG_KEY_LAST:  key_last_reg  <= cfg_data[15:0];
                REG_EVENT_CNT: event_cnt_reg <= cfg_data;
                REG_TIME_STEP: step_reg      <= cfg_data[7:0];
                default:       step_reg      <= step_reg;
            endcase
        end
    end

    phase_t       phase_reg;
    logic [1:0]   pass_reg;
    logic [6:0]   cnt_reg;
    logic [63:0]  quo_reg;
    logic [8:0]   rem_reg;
    logic [63:0]  factor_reg;
    logic [19:0]  cand_reg;
    logic [159:0] h_reg, inner_reg;
    logic [31:0]  bin_reg;
    logic [31:0]  mq_reg;
    logic [MODW+4:0] mrem_reg;
    logic [7:0]   dstep;

    assign dstep = (step_reg == 8'd0) ? 8'd1 : step_reg;

    // key blocks and message blocks
    logic [511:0] key_blk, sha_block;
    logic [159:0] sha_hin, sha_hout;
    logic         sha_start, sha_done;

    assign key_blk = {key_first_reg, key_last_reg, 432'd0};

    always_comb
    begin
        case (pass_reg)
            2'd0: sha_block = key_blk ^ {64{PAD_INNER}};
            2'd1: sha_block = {factor_reg, 8'h80, 376'd0, 64'd576};
            2'd2: sha_block = key_blk ^ {64{PAD_OUTER}};
            default: sha_block = {inner_reg, 8'h80, 280'd0, 64'd672};
        endcase
        sha_hin = (pass_reg == 2'd0 || pass_reg == 2'd2) ? SHA1_IV : h_reg;
    end

    assign sha_start = (phase_reg == P_SHA_GO);

    hotp_sha1 u_sha1 (
        .clk  (clk),
        .rst_n(rst_n),
        .start(sha_start),
        .h_in (sha_hin),
        .block(sha_block),
        .done (sha_done),
        .h_out(sha_hout)
    );

    // dynamic truncation of the final digest
    logic [3:0]   off;
    logic [159:0] shifted;
    assign off     = sha_hout[3:0];
    assign shifted = sha_hout << {off, 3'b000};

    // restoring divide step for the time window
    logic [8:0]  rtry;
    assign rtry = {rem_reg[7:0], quo_reg[63]};

    // modulo by reciprocal multiply, back-multiply and one correction
    logic [63:0] mprod, mqm;
    assign mprod = {32'd0, bin_reg} * {32'd0, RECIP};
    assign mqm   = {32'd0, mq_reg} * {37'd0, MODULUS};

    assign in_stall = (phase_reg != P_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            out_valid <= 1'b0;
            pass_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (phase_reg)
                P_IDLE:
                begin
                    if (in_valid)
                    begin
                        cand_reg <= in_data.candidate_code;
                        quo_reg  <= {1'b0, in_data.time_seconds};
                        rem_reg  <= '0;
                        cnt_reg  <= '0;
                        pass_reg <= 2'd0;
                        if (in_data.mode)
                            phase_reg <= P_DIV;
                        else
                        begin
                            factor_reg <= event_cnt_reg;
                            phase_reg  <= P_SHA_GO;
                        end
                    end
                end
                P_DIV:
                begin
                    if (rtry >= {1'b0, dstep})
                    begin
                        rem_reg <= rtry - {1'b0, dstep};
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rtry;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63)
                    begin
                        factor_reg <= (rtry >= {1'b0, dstep}) ? {quo_reg[62:0], 1'b1}
                                                             : {quo_reg[62:0], 1'b0};
                        phase_reg  <= P_SHA_GO;
                    end
                end
                P_SHA_GO:
                begin
                    phase_reg <= P_SHA_WAIT;
                end
                P_SHA_WAIT:
                begin
                    if (sha_done)
                    begin
                        h_reg    <= sha_hout;
                        pass_reg <= pass_reg + 2'd1;
                        if (pass_reg == 2'd1)
                            inner_reg <= sha_hout;
                        if (pass_reg == 2'd3)
                        begin
                            bin_reg   <= {1'b0, shifted[158:128]};
                            mrem_reg  <= '0;
                            cnt_reg   <= '0;
                            phase_reg <= P_MOD;
                        end
                        else
                            phase_reg <= P_SHA_GO;
                    end
                end
                P_MOD:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    case (cnt_reg)
                        7'd0: mq_reg <= mprod[63:32];
                        7'd1: mrem_reg <= bin_reg - mqm[31:0];
                        default:
                        begin
                            if (mrem_reg >= {5'd0, MODULUS})
                                mrem_reg <= mrem_reg - {5'd0, MODULUS};
                            phase_reg <= P_OUT;
                        end
                    endcase
                end
                P_OUT:
                begin
                    if (!out_valid)
                    begin
                        out_data.code_valid    <= ({12'd0, cand_reg} == mrem_reg);
                        out_data.expected_code <= mrem_reg[19:0];
                        out_valid              <= 1'b1;
                    end
                    else if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        phase_reg <= P_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    // no input accepted while an item is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != P_IDLE |-> in_stall)
        else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> phase_reg == P_OUT)
        else $error("result shown outside output phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        sha_start |=> !sha_done)
        else $error("hash finished too early");

endmodule

`default_nettype wire

[hw/rtl/hotp_ram.sv]
// ----------------------------------------------------------------------------
// hotp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hotp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/hotp_sha1.sv]
// ----------------------------------------------------------------------------
// hotp_sha1
// One SHA-1 compression, one round per cycle; schedule words kept in a
// 16-entry RAM that is read for the next round's word and written back in place.
// ----------------------------------------------------------------------------
`default_nettype none

module hotp_sha1 (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [159:0] h_in,
    input  wire logic [511:0] block,
    output logic              done,
    output logic      [159:0] h_out
);

    import hotp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ROUND, S_FIN} state_t;

    state_t      state_reg;
    logic [6:0]  rnd_reg;
    logic [4:0]  ld_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [511:0] blk_reg;
    logic [31:0] wm3_reg, wm8_reg, wm14_reg;

    // schedule memory: four read ports would be needed for w[i-3..i-16], so
    // the window is held as one RAM for w[i-16] plus the 13-word lag shifter
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;

    hotp_ram #(.WIDTH(32), .DEPTH(16)) u_wram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    logic [31:0] w_new;
    logic [31:0] w_use;
    logic [31:0] t_val;

    // w[i] for i >= 16 from the window: w[i-16] from ram, others from shifter
    assign w_new = ({wm3_reg ^ wm8_reg ^ wm14_reg ^ rd_data} << 1)
                 | ({wm3_reg ^ wm8_reg ^ wm14_reg ^ rd_data} >> 31);
    assign w_use = (rnd_reg < 7'd16) ? rd_data : w_new;
    assign t_val = {a_reg[26:0], a_reg[31:27]} + sha1_f(rnd_reg, b_reg, c_reg, d_reg)
                 + e_reg + sha1_k(rnd_reg) + w_use;

    // ram control: load the block, then read-modify-write one word per round
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rnd_reg[3:0];
        wr_data = w_use;
        rd_addr = rnd_reg[3:0];
        case (state_reg)
            S_LOAD:
            begin
                wr_en   = 1'b1;
                wr_addr = ld_reg[3:0];
                wr_data = blk_reg[511:480];
                rd_addr = 4'd0;
            end
            S_ROUND:
            begin
                wr_en   = 1'b1;
                rd_addr = rnd_reg[3:0] + 4'd1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // sequencer and working variables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
            rnd_reg   <= '0;
            ld_reg    <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        blk_reg   <= block;
                        h_out     <= h_in;
                        {a_reg, b_reg, c_reg, d_reg, e_reg} <= h_in;
                        ld_reg    <= '0;
                        rnd_reg   <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    blk_reg <= {blk_reg[479:0], 32'd0};
                    ld_reg  <= ld_reg + 5'd1;
                    if (ld_reg == 5'd15)
                        state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    e_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    b_reg <= a_reg;
                    a_reg <= t_val;
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd79)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    h_out <= {h_out[159:128] + a_reg, h_out[127:96] + b_reg,
                              h_out[95:64] + c_reg, h_out[63:32] + d_reg,
                              h_out[31:0] + e_reg};
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // tap registers w[i-3], w[i-8], w[i-14] follow the window in rounds.
    // they need w at lags 2,7,13 of the current word; kept in one 13-word shifter
    logic [31:0] lag_reg [13];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            lag_reg[0] <= blk_reg[511:480];
            for (int i = 1; i < 13; i++)
                lag_reg[i] <= lag_reg[i-1];
        end
        else if (state_reg == S_ROUND)
        begin
            lag_reg[0] <= w_use;
            for (int i = 1; i < 13; i++)
                lag_reg[i] <= lag_reg[i-1];
        end
    end

    // next round's taps: w[i+1-3]=lag1 after shift -> current lag_reg[1]
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROUND)
        begin
            wm3_reg  <= lag_reg[1];
            wm8_reg  <= lag_reg[6];
            wm14_reg <= lag_reg[12];
        end
    end

    // round counter stays inside the schedule
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND |-> rnd_reg < 7'd80)
        else $error("round counter out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_FIN)
        else $error("done without final add");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |-> ld_reg < 5'd16)
        else $error("load counter out of range");

endmodule

`default_nettype wire
